>>> rtl/bpfa_pkg.sv
// Package: widths, default sizes and codes of the bitmap page frame allocator.
`timescale 1ns / 1ps
`default_nettype none
package bpfa_pkg;

	localparam int BPFA_MAX_PAGES     = 65536;
	localparam int BPFA_MAP_WORD_BITS = 64;

	localparam int CMD_W   = 3;
	localparam int PAGE_W  = 16;
	localparam int RUN_W   = 8;
	localparam int CNT_W   = 17;
	localparam int STAT_W  = 2;

	localparam logic [CNT_W-1:0] TOTAL_RESET = 17'h10000;

	localparam logic [CMD_W-1:0] CMD_LOCK      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_FREE      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RESERVE   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_UNRESERVE = 3'd3;
	localparam logic [CMD_W-1:0] CMD_REQUEST   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_INIT      = 3'd5;

	localparam logic [STAT_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_NO_FREE = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_RANGE   = 2'd2;

endpackage
`default_nettype wire

>>> rtl/bitmap_page_frame_allocator.sv
// Top level: bitmap page frame allocator with one map memory and a command sequencer.
// Lock/free/reserve/unreserve: each page of the run is set or cleared in turn; one map word
//   is read and written back per word of the run.
// Request: map words are scanned in order up to the first free page;
//   the registered read of the map memory sets the scan rate.
// Init and reset: a clearing pass writes zero to every map word (1024 by default);
//   no item is accepted during the pass after reset. One item is worked on at a time.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_page_frame_allocator
	import bpfa_pkg::*;
#(
	parameter int MAX_PAGES     = BPFA_MAX_PAGES,
	parameter int MAP_WORD_BITS = BPFA_MAP_WORD_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CNT_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [PAGE_W-1:0] page_index,
	input  wire logic [RUN_W-1:0]  page_count,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [STAT_W-1:0]      status,
	output logic [PAGE_W-1:0]      found_page,
	output logic [CNT_W-1:0]       free_pages,
	output logic [CNT_W-1:0]       used_pages,
	output logic [CNT_W-1:0]       reserved_pages
);

	localparam int WB_LOG2 = $clog2(MAP_WORD_BITS);
	localparam int WORD_W  = 1 << WB_LOG2;
	localparam int DEPTH   = (MAX_PAGES + WORD_W - 1) / WORD_W;
	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int BASE_W  = CNT_W + 1;
	localparam int EXT_W   = (ADDR_W + WB_LOG2 > BASE_W) ? ADDR_W + WB_LOG2 : BASE_W;
	localparam logic [CNT_W-1:0] CAP =
		(MAX_PAGES > 131071) ? 17'h1FFFF : CNT_W'(MAX_PAGES);
	localparam logic [CNT_W-1:0] FREE_RESET = (TOTAL_RESET > CAP) ? CAP : TOTAL_RESET;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RUN_LOAD,
		ST_RUN_BIT,
		ST_REQ_CHECK,
		ST_DONE
	} state_t;

	function automatic logic [ADDR_W-1:0] word_addr(input logic [BASE_W-1:0] p);
		logic [EXT_W-1:0] pe;
		pe = EXT_W'(p);
		return pe[WB_LOG2 +: ADDR_W];
	endfunction

	function automatic logic [WB_LOG2-1:0] low_zero(input logic [WORD_W-1:0] w);
		logic [WB_LOG2-1:0] r;
		r = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) r = WB_LOG2'(i);
		end
		return r;
	endfunction

	state_t              state_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    free_q;
	logic [CNT_W-1:0]    used_q;
	logic [CNT_W-1:0]    rsv_q;
	logic [CMD_W-1:0]    cmd_q;
	logic [CNT_W-1:0]    idx_q;
	logic [RUN_W-1:0]    rem_q;
	logic [BASE_W-1:0]   base_q;
	logic [ADDR_W-1:0]   clr_q;
	logic                init_q;
	logic [WORD_W-1:0]   word_q;
	logic [STAT_W-1:0]   status_q;
	logic [PAGE_W-1:0]   found_q;
	logic                out_valid_q;
	logic [STAT_W-1:0]   out_status_q;
	logic [PAGE_W-1:0]   out_found_q;
	logic [CNT_W-1:0]    out_free_q;
	logic [CNT_W-1:0]    out_used_q;
	logic [CNT_W-1:0]    out_rsv_q;

	logic [WORD_W-1:0]   map_mem [DEPTH];
	logic [WORD_W-1:0]   rd_word_q;

	logic [CNT_W-1:0]    eff_total;
	logic                target;
	logic [WB_LOG2-1:0]  bit_pos;
	logic                bit_flip;
	logic [WORD_W-1:0]   run_word;
	logic [CNT_W-1:0]    idx_next;
	logic                run_last;
	logic                next_out;
	logic                word_end;
	logic                has_zero;
	logic [WB_LOG2-1:0]  zero_pos;
	logic [BASE_W-1:0]   cand;
	logic                cand_ok;
	logic [BASE_W-1:0]   base_next;
	logic                accept;
	logic                out_free_slot;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [WORD_W-1:0]   mem_wdata;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_raddr;

	assign eff_total     = (total_q > CAP) ? CAP : total_q;
	assign in_stall      = (state_q != ST_IDLE);
	assign accept        = in_valid && !in_stall;
	assign out_free_slot = !out_valid_q || !out_stall;

	assign target   = (cmd_q == CMD_LOCK) || (cmd_q == CMD_RESERVE);
	assign bit_pos  = idx_q[WB_LOG2-1:0];
	assign bit_flip = (word_q[bit_pos] != target);
	assign idx_next = idx_q + CNT_W'(1);
	assign run_last = (rem_q == RUN_W'(1));
	assign next_out = (idx_next >= eff_total);
	assign word_end = (bit_pos == WB_LOG2'(WORD_W - 1));

	always_comb begin
		run_word          = word_q;
		run_word[bit_pos] = target;
	end

	assign has_zero  = !(&rd_word_q);
	assign zero_pos  = low_zero(rd_word_q);
	assign cand      = base_q + BASE_W'(zero_pos);
	assign cand_ok   = has_zero && (cand < {1'b0, eff_total});
	assign base_next = base_q + BASE_W'(WORD_W);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = word_addr({1'b0, idx_q});
		mem_wdata = run_word;
		mem_re    = 1'b0;
		mem_raddr = word_addr({1'b0, idx_next});
		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				if (accept && command == CMD_REQUEST) begin
					mem_re    = 1'b1;
					mem_raddr = '0;
				end else if (accept) begin
					mem_re    = 1'b1;
					mem_raddr = word_addr({2'b00, page_index});
				end
			end
			ST_RUN_BIT: begin
				mem_we = run_last || next_out || word_end;
				mem_re = !run_last && !next_out && word_end;
			end
			ST_REQ_CHECK: begin
				mem_waddr = word_addr(base_q);
				mem_wdata = rd_word_q | (WORD_W'(1) << zero_pos);
				mem_we    = cand_ok;
				mem_re    = !has_zero && (base_next < {1'b0, eff_total});
				mem_raddr = word_addr(base_next);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_word_q <= map_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			total_q     <= TOTAL_RESET;
			free_q      <= FREE_RESET;
			used_q      <= '0;
			rsv_q       <= '0;
			cmd_q       <= CMD_LOCK;
			idx_q       <= '0;
			rem_q       <= '0;
			base_q      <= '0;
			clr_q       <= '0;
			init_q      <= 1'b0;
			word_q      <= '0;
			status_q    <= STATUS_OK;
			found_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				total_q <= cfg_wr_data;
			end
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == LAST_ADDR) begin
						clr_q <= '0;
						if (init_q) begin
							free_q  <= eff_total;
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_IDLE: begin
					if (accept) begin
						cmd_q    <= command;
						idx_q    <= {1'b0, page_index};
						rem_q    <= page_count;
						base_q   <= '0;
						status_q <= STATUS_OK;
						found_q  <= '0;
						init_q   <= 1'b0;
						unique case (command) inside
							CMD_LOCK, CMD_FREE, CMD_RESERVE, CMD_UNRESERVE: begin
								if (page_count == '0) begin
									state_q <= ST_DONE;
								end else if ({1'b0, page_index} >= eff_total) begin
									status_q <= STATUS_RANGE;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_RUN_LOAD;
								end
							end
							CMD_REQUEST: begin
								if (eff_total == '0) begin
									status_q <= STATUS_NO_FREE;
									state_q  <= ST_DONE;
								end else begin
									state_q <= ST_REQ_CHECK;
								end
							end
							CMD_INIT: begin
								init_q  <= 1'b1;
								clr_q   <= '0;
								state_q <= ST_CLEAR;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RUN_LOAD: begin
					word_q  <= rd_word_q;
					state_q <= ST_RUN_BIT;
				end
				ST_RUN_BIT: begin
					word_q <= run_word;
					if (bit_flip) begin
						free_q <= target ? free_q - CNT_W'(1) : free_q + CNT_W'(1);
						case (cmd_q)
							CMD_LOCK:    used_q <= used_q + CNT_W'(1);
							CMD_FREE:    used_q <= used_q - CNT_W'(1);
							CMD_RESERVE: rsv_q  <= rsv_q + CNT_W'(1);
							default:     rsv_q  <= rsv_q - CNT_W'(1);
						endcase
					end
					idx_q <= idx_next;
					rem_q <= rem_q - RUN_W'(1);
					if (run_last) begin
						state_q <= ST_DONE;
					end else if (next_out) begin
						status_q <= STATUS_RANGE;
						state_q  <= ST_DONE;
					end else if (word_end) begin
						state_q <= ST_RUN_LOAD;
					end
				end
				ST_REQ_CHECK: begin
					if (has_zero) begin
						if (cand_ok) begin
							found_q <= cand[PAGE_W-1:0];
							free_q  <= free_q - CNT_W'(1);
							used_q  <= used_q + CNT_W'(1);
						end else begin
							status_q <= STATUS_NO_FREE;
						end
						state_q <= ST_DONE;
					end else if (base_next >= {1'b0, eff_total}) begin
						status_q <= STATUS_NO_FREE;
						state_q  <= ST_DONE;
					end else begin
						base_q <= base_next;
					end
				end
				ST_DONE: begin
					if (out_free_slot) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free_slot) begin
			out_status_q <= status_q;
			out_found_q  <= found_q;
			out_free_q   <= free_q;
			out_used_q   <= used_q;
			out_rsv_q    <= rsv_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = out_status_q;
	assign found_page     = out_found_q;
	assign free_pages     = out_free_q;
	assign used_pages     = out_used_q;
	assign reserved_pages = out_rsv_q;

	a_clear_blocks_items: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> in_stall)
		else $error("item taken during clearing pass");

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we && mem_re |-> mem_waddr != mem_raddr)
		else $error("map read and write hit the same word");

	a_run_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN_BIT |-> rem_q != '0 && idx_q < eff_total)
		else $error("run step outside the run or the page total");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REQ_CHECK |-> base_q < {1'b0, eff_total})
		else $error("request scan beyond the page total");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_DONE)
		else $error("result shown without a finished item");

endmodule
`default_nettype wire

>>> bench/bitmap_page_frame_allocator_checker.sv
// Checker: predicts allocator replies from accepted commands and compares them with the output channel.
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_checker
	import bpfa_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [CNT_W-1:0]  cfg_wr_data,
	input  wire logic              in_valid,
	input  wire logic              in_stall,
	input  wire logic [CMD_W-1:0]  command,
	input  wire logic [PAGE_W-1:0] page_index,
	input  wire logic [RUN_W-1:0]  page_count,
	input  wire logic              out_valid,
	input  wire logic              out_stall,
	input  wire logic [STAT_W-1:0] status,
	input  wire logic [PAGE_W-1:0] found_page,
	input  wire logic [CNT_W-1:0]  free_pages,
	input  wire logic [CNT_W-1:0]  used_pages,
	input  wire logic [CNT_W-1:0]  reserved_pages,
	output int                     fail_count,
	output int                     pending
);

	localparam int MAP_WORDS = BPFA_MAX_PAGES / BPFA_MAP_WORD_BITS;

	typedef struct packed {
		logic [STAT_W-1:0] st;
		logic [PAGE_W-1:0] page;
		logic [CNT_W-1:0]  free_n;
		logic [CNT_W-1:0]  used_n;
		logic [CNT_W-1:0]  rsvd_n;
	} reply_t;

	logic [BPFA_MAP_WORD_BITS-1:0] page_map [0:MAP_WORDS-1];
	logic [CNT_W-1:0] total_reg;
	logic [CNT_W-1:0] free_cnt;
	logic [CNT_W-1:0] used_cnt;
	logic [CNT_W-1:0] rsvd_cnt;
	reply_t replies_due [$];
	int errs;

	function automatic int unsigned managed_pages();
		if (total_reg > BPFA_MAX_PAGES) return BPFA_MAX_PAGES;
		return total_reg;
	endfunction

	task automatic touch_page(input int unsigned idx, input logic [CMD_W-1:0] cmd,
			output bit in_range);
		bit target;
		int unsigned w;
		int unsigned b;
		target = (cmd == CMD_LOCK) || (cmd == CMD_RESERVE);
		in_range = idx < managed_pages();
		w = idx / BPFA_MAP_WORD_BITS;
		b = idx % BPFA_MAP_WORD_BITS;
		if (in_range && page_map[w][b] != target) begin
			page_map[w][b] = target;
			if (target) free_cnt = free_cnt - 1'b1;
			else free_cnt = free_cnt + 1'b1;
			case (cmd)
				CMD_LOCK:    used_cnt = used_cnt + 1'b1;
				CMD_FREE:    used_cnt = used_cnt - 1'b1;
				CMD_RESERVE: rsvd_cnt = rsvd_cnt + 1'b1;
				default:     rsvd_cnt = rsvd_cnt - 1'b1;
			endcase
		end
	endtask

	task automatic predict_reply(input logic [CMD_W-1:0] cmd, input logic [PAGE_W-1:0] first,
			input logic [RUN_W-1:0] run, output reply_t r);
		bit ok;
		bit hit;
		int unsigned t;
		int unsigned n;
		int unsigned w;
		r = '0;
		r.st = STATUS_OK;
		if (cmd <= CMD_UNRESERVE) begin
			for (t = 0; t < run; t++) begin
				touch_page(first + t, cmd, ok);
				if (!ok) r.st = STATUS_RANGE;
			end
		end else if (cmd == CMD_REQUEST) begin
			n = managed_pages();
			r.st = STATUS_NO_FREE;
			t = 0;
			hit = 1'b0;
			while (t < n && !hit) begin
				w = t / BPFA_MAP_WORD_BITS;
				if (&page_map[w]) begin
					t = (w + 1) * BPFA_MAP_WORD_BITS;
				end else if (!page_map[w][t % BPFA_MAP_WORD_BITS]) begin
					touch_page(t, CMD_LOCK, ok);
					r.page = t[PAGE_W-1:0];
					r.st = STATUS_OK;
					hit = 1'b1;
				end else begin
					t++;
				end
			end
		end else if (cmd == CMD_INIT) begin
			for (int i = 0; i < MAP_WORDS; i++) page_map[i] = '0;
			free_cnt = CNT_W'(managed_pages());
		end
		r.free_n = free_cnt;
		r.used_n = used_cnt;
		r.rsvd_n = rsvd_cnt;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t want;
		reply_t got;
		if (!arst_n) begin
			for (int i = 0; i < MAP_WORDS; i++) page_map[i] = '0;
			total_reg = TOTAL_RESET;
			free_cnt = CNT_W'(managed_pages());
			used_cnt = '0;
			rsvd_cnt = '0;
			replies_due.delete();
			errs = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) total_reg = cfg_wr_data;
			if (in_valid && !in_stall) begin
				predict_reply(command, page_index, page_count, want);
				replies_due.push_back(want);
			end
			if (out_valid && !out_stall) begin
				got = {status, found_page, free_pages, used_pages, reserved_pages};
				if (replies_due.size() == 0) begin
					if (errs < 10)
						$display("%0t unexpected item: st=%0d page=%0d free=%0d used=%0d rsv=%0d",
							$realtime, got.st, got.page, got.free_n, got.used_n, got.rsvd_n);
					errs++;
				end else begin
					want = replies_due.pop_front();
					if (got.st !== want.st || got.page !== want.page ||
							got.free_n !== want.free_n || got.used_n !== want.used_n ||
							got.rsvd_n !== want.rsvd_n) begin
						if (errs < 10) begin
							$display("%0t mismatch exp: st=%0d page=%0d free=%0d used=%0d rsv=%0d",
								$realtime, want.st, want.page, want.free_n, want.used_n,
								want.rsvd_n);
							$display("%0t          got: st=%0d page=%0d free=%0d used=%0d rsv=%0d",
								$realtime, got.st, got.page, got.free_n, got.used_n,
								got.rsvd_n);
						end
						errs++;
					end
				end
			end
			fail_count <= errs;
			pending <= replies_due.size();
		end
	end

endmodule

>>> bench/bitmap_page_frame_allocator_tb.sv
// Testbench top: drives allocator commands and page totals, and gives the verdict.
`timescale 1ns / 1ps
module bitmap_page_frame_allocator_tb;
	import bpfa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_6 = 3'd6;
	localparam logic [CMD_W-1:0] CMD_UNUSED_7 = 3'd7;
	localparam int CYCLE_LIMIT  = 8000000;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 225;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [CNT_W-1:0]  cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [CMD_W-1:0]  command = '0;
	logic [PAGE_W-1:0] page_index = '0;
	logic [RUN_W-1:0]  page_count = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [STAT_W-1:0] status;
	logic [PAGE_W-1:0] found_page;
	logic [CNT_W-1:0]  free_pages;
	logic [CNT_W-1:0]  used_pages;
	logic [CNT_W-1:0]  reserved_pages;
	int                fail_count;
	int                pending;
	int                cycles = 0;
	bit                gaps_on = 1'b1;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	bitmap_page_frame_allocator i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.page_index     (page_index),
		.page_count     (page_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_page     (found_page),
		.free_pages     (free_pages),
		.used_pages     (used_pages),
		.reserved_pages (reserved_pages)
	);

	bitmap_page_frame_allocator_checker i_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.command        (command),
		.page_index     (page_index),
		.page_count     (page_count),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.found_page     (found_page),
		.free_pages     (free_pages),
		.used_pages     (used_pages),
		.reserved_pages (reserved_pages),
		.fail_count     (fail_count),
		.pending        (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : sink
		int n;
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 7);
				out_stall = 1'b1;
				repeat (n) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic send_item(input logic [CMD_W-1:0] cmd, input int unsigned first,
			input int unsigned run);
		int n;
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 7);
			in_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		in_valid = 1'b1;
		command = cmd;
		page_index = first[PAGE_W-1:0];
		page_count = run[RUN_W-1:0];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_total(input int unsigned pages);
		drain();
		cfg_wr_en = 1'b1;
		cfg_wr_data = pages[CNT_W-1:0];
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic random_item(input int unsigned span);
		int r;
		logic [CMD_W-1:0] cmd;
		int unsigned first;
		int unsigned run;
		r = $urandom_range(0, 99);
		if (r < 22) cmd = CMD_LOCK;
		else if (r < 44) cmd = CMD_FREE;
		else if (r < 59) cmd = CMD_RESERVE;
		else if (r < 74) cmd = CMD_UNRESERVE;
		else if (r < 92) cmd = CMD_REQUEST;
		else if (r < 96) cmd = CMD_INIT;
		else if (r < 98) cmd = CMD_UNUSED_6;
		else cmd = CMD_UNUSED_7;
		r = $urandom_range(0, 9);
		if (span > 1024) begin
			if (r < 4) first = $urandom_range(0, 1023);
			else if (r < 7) first = $urandom_range(span - 300, 65535);
			else first = $urandom_range(0, 65535);
		end else begin
			if (r < 9) first = $urandom_range(0, span + 16);
			else first = $urandom_range(0, 65535);
		end
		r = $urandom_range(0, 9);
		if (r == 0) run = 0;
		else if (r == 1) run = 255;
		else if (r < 4) run = $urandom_range(0, 255);
		else run = $urandom_range(1, 24);
		send_item(cmd, first, run);
	endtask

	initial begin : stimulus
		int unsigned totals [PHASES];
		int unsigned span;
		totals = '{64, 200, 131071, 65536, 1, 700, 0, 4096};
		totals[6] = $urandom_range(2, 131070);
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		send_item(CMD_REQUEST, 0, 0);
		send_item(CMD_LOCK, 65535, 255);
		send_item(CMD_LOCK, 16'hFF00, 0);
		send_item(CMD_LOCK, 1, 255);
		send_item(CMD_LOCK, 256, 255);
		send_item(CMD_REQUEST, 0, 0);
		send_item(CMD_RESERVE, 500, 20);
		send_item(CMD_FREE, 510, 5);
		send_item(CMD_UNRESERVE, 505, 10);
		send_item(CMD_UNUSED_6, 16'h5555, 8'hAA);
		send_item(CMD_UNUSED_7, 16'hAAAA, 8'h55);
		send_item(CMD_INIT, 0, 0);
		send_item(CMD_FREE, 0, 3);

		write_total(1);
		send_item(CMD_INIT, 16'hFFFF, 8'hFF);
		send_item(CMD_REQUEST, 0, 0);
		send_item(CMD_REQUEST, 0, 0);
		send_item(CMD_UNRESERVE, 0, 3);
		write_total(100);
		send_item(CMD_LOCK, 0, 100);
		send_item(CMD_UNRESERVE, 0, 100);
		send_item(CMD_REQUEST, 0, 0);
		write_total(131071);
		send_item(CMD_REQUEST, 0, 0);

		for (int k = 0; k < PHASES; k++) begin
			write_total(totals[k]);
			span = (totals[k] > BPFA_MAX_PAGES) ? BPFA_MAX_PAGES : totals[k];
			gaps_on = (k != 4) && (k != PHASES - 1);
			if ($urandom_range(0, 3) != 0) send_item(CMD_INIT, $urandom, $urandom);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (k == 2 && i == PHASE_ITEMS / 2) drain();
				random_item(span);
			end
		end

		drain();
		repeat (64) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> filelist.f
rtl/bpfa_pkg.sv
rtl/bitmap_page_frame_allocator.sv
bench/bitmap_page_frame_allocator_checker.sv
bench/bitmap_page_frame_allocator_tb.sv
